// File: rtl/core/sxfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxfr_pkg
// Shared types, constants and the CRC-8 step for the STX/ETX frame receiver.
// ----------------------------------------------------------------------------
package sxfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int CFG_INDEX_W     = 8;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_START_CODE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_CODE   = 8'd1;

  localparam logic [7:0] START_CODE_RST = 8'h02;
  localparam logic [7:0] END_CODE_RST   = 8'h03;
  localparam logic [7:0] CRC_POLY       = 8'h8C;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_BYTE,
    EMIT_CRC_ERR,
    EMIT_OVERFLOW,
    EMIT_EMPTY
  } emit_t;

  typedef struct packed {
    logic  open_frame;
    logic  store_byte;
    logic  rd_clear;
    logic  rd_issue;
    logic  rd_next;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_end;
    logic count_full;
    logic count_zero;
    logic crc_match;
    logic last_idx;
    logic slot_free;
  } stat_t;

  // reflected CRC-8, one byte folded LSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    logic       mix;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ b[i];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sxfr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sxfr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sxfr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxfr_ctrl
// Frame state machine: hunt, collect payload, check byte, payload drain.
// ----------------------------------------------------------------------------
module sxfr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire sxfr_pkg::stat_t stat,
  output sxfr_pkg::cmd_t       cmd
);
  import sxfr_pkg::*;

  typedef enum logic [4:0] {
    ST_HUNT  = 5'b00001,
    ST_DATA  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_RD    = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    unique case (state)
      ST_HUNT:  s_tready = 1'b1;
      ST_DATA:  s_tready = stat.slot_free | ~stat.count_full;
      ST_CHECK: s_tready = stat.slot_free;
      ST_RD:    s_tready = 1'b0;
      ST_OUT:   s_tready = 1'b0;
      default:  s_tready = 1'b0;
    endcase
  end

  assign accept = s_tvalid & s_tready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.emit       = EMIT_NONE;
    unique case (state)
      ST_HUNT: begin
        if (accept && stat.is_start) begin
          cmd.open_frame = 1'b1;
          state_next     = ST_DATA;
        end
      end
      ST_DATA: begin
        if (accept) begin
          if (stat.is_start) begin
            cmd.open_frame = 1'b1;
          end else if (stat.is_end) begin
            state_next = ST_CHECK;
          end else if (stat.count_full) begin
            cmd.emit   = EMIT_OVERFLOW;
            state_next = ST_HUNT;
          end else begin
            cmd.store_byte = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (accept) begin
          state_next = ST_HUNT;
          if (!stat.crc_match) begin
            cmd.emit = EMIT_CRC_ERR;
          end else if (stat.count_zero) begin
            cmd.emit = EMIT_EMPTY;
          end else begin
            cmd.rd_clear = 1'b1;
            state_next   = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (stat.slot_free) begin
          cmd.emit = EMIT_BYTE;
          if (stat.last_idx) begin
            state_next = ST_HUNT;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = ST_RD;
          end
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_no_input_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD || state == ST_OUT) |-> !s_tready)
    else $error("input accepted during payload drain");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && stat.slot_free && stat.last_idx) |=> state == ST_HUNT)
    else $error("drain did not return to hunting after last byte");

  a_read_before_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !$past(state == ST_OUT)) |-> $past(state == ST_RD))
    else $error("output step without a preceding read");
`endif

endmodule
`default_nettype wire

// File: rtl/core/sxfr_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sxfr_dpath
// Code registers, CRC, payload count, payload store and output register.
// ----------------------------------------------------------------------------
module sxfr_dpath #(
  parameter int MAX_PAYLOAD = sxfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [sxfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data,
  input  wire logic [7:0]                       rx_byte,
  input  wire sxfr_pkg::cmd_t                   cmd,
  output sxfr_pkg::stat_t                       stat,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sxfr_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                  m_tlast
);
  import sxfr_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]    start_code;
  logic [7:0]    end_code;
  logic [7:0]    crc;
  logic [CW-1:0] count;
  logic [AW-1:0] rd_idx;
  logic [7:0]    rd_data;
  logic [7:0]    count8;
  logic [5:0]    len;

  logic [1:0]    o_status;
  logic [7:0]    o_byte;
  logic          o_byte_valid;
  logic [5:0]    o_length;

  assign count8 = 8'(count);
  assign len    = (count8 > 8'd63) ? 6'd63 : count8[5:0];

  assign stat.is_start   = (rx_byte == start_code);
  assign stat.is_end     = (rx_byte == end_code);
  assign stat.count_full = (count8 == 8'(MAX_PAYLOAD));
  assign stat.count_zero = (count == '0);
  assign stat.crc_match  = (rx_byte == crc);
  assign stat.last_idx   = ((8'(rd_idx) + 8'd1) == count8);
  assign stat.slot_free  = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= START_CODE_RST;
      end_code   <= END_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_CODE: start_code <= cfg_data;
        REG_END_CODE:   end_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc   <= '0;
      count <= '0;
    end else if (cmd.open_frame) begin
      crc   <= '0;
      count <= '0;
    end else if (cmd.store_byte) begin
      crc   <= crc8_fold(crc, rx_byte);
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.rd_clear) begin
      rd_idx <= '0;
    end else if (cmd.rd_next) begin
      rd_idx <= rd_idx + AW'(1);
    end
  end

  sxfr_ram #(
    .WIDTH  (8),
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (AW)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (count[AW-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EMIT_NONE) begin
      o_length     <= len;
      o_byte       <= (cmd.emit == EMIT_BYTE) ? rd_data : 8'd0;
      o_byte_valid <= (cmd.emit == EMIT_BYTE);
      m_tlast      <= (cmd.emit == EMIT_BYTE) ? stat.last_idx : 1'b1;
      case (cmd.emit)
        EMIT_CRC_ERR:  o_status <= STATUS_CRC_ERR;
        EMIT_OVERFLOW: o_status <= STATUS_OVERFLOW;
        default:       o_status <= STATUS_GOOD;
      endcase
    end
  end

  // status, payload_byte, byte_valid, frame_length from bit 0 up
  assign m_tdata = {7'd0, o_length, o_byte_valid, o_byte, o_status};

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != EMIT_NONE) |-> stat.slot_free)
    else $error("result issued while output register held");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count8 <= 8'(MAX_PAYLOAD))
    else $error("payload count beyond limit");

  a_no_store_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.store_byte |-> !stat.count_full)
    else $error("payload write past store depth");
`endif

endmodule
`default_nettype wire

// File: rtl/core/stx_etx_frame_receiver_crc8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_crc8
// STX/ETX framed byte receiver with reflected CRC-8 (poly 0x8C, init 0).
//
// s_* channel takes one received byte per request. Bytes before the start
// code are dropped; payload bytes are stored and folded into the CRC until
// the end code; the byte after that is the check byte.
// m_* channel returns results: the payload bytes of a good frame (tlast on
// the final one), or a single crc error / overflow / empty-frame result.
// cfg_* writes start_code (index 0) and end_code (index 1); always ready.
// Throughput: one input byte per cycle while hunting or collecting.
// Error, overflow and empty results appear in the cycle after the request
// that causes them. A good frame drains from the payload RAM byte by
// byte: each byte is read, then loaded into the output register once it is
// free; s_tready is low during the drain.
// When m_tready is low the single output register holds the result and
// s_tready drops only for a byte that could produce another result.
// Reset (rst, synchronous) restores codes 0x02/0x03 and starts hunting.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver_crc8 #(
  parameter int MAX_PAYLOAD = sxfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sxfr_pkg::IN_TDATA_W-1:0]  s_tdata,   // rx_byte
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // status[1:0], payload_byte[9:2], byte_valid[10], frame_length[16:11]
  output logic [sxfr_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                  m_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sxfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data
);
  import sxfr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  sxfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sxfr_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire
